/* src/bitmap_slot_allocator_top_assert.svh */
// Assertion macros for the bitmap slot allocator top level.
`ifndef BITMAP_SLOT_ALLOCATOR_TOP_ASSERT_SVH
`define BITMAP_SLOT_ALLOCATOR_TOP_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define BSA_CHECK_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the following cycle.
`define BSA_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/bsa_pkg.sv */
// Shared types and constants for the bitmap slot allocator.
package bsa_pkg;

  localparam int ADDR_W        = 21;
  localparam int SIZE_W        = 4;
  localparam int STAT_W        = 2;
  localparam int PADDR_W       = 3;
  localparam int PDATA_W       = 32;
  localparam int SIZE_LOG2_MAX = 12;

  // Register index of size_log2
  localparam logic REG_SIZE_LOG2 = 1'b0;

  // Request functions
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] ST_DOUBLE = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE  = 2'd3;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;    // capture request
    logic look;    // slot index, range check, chunk search
    logic rd;      // chunk/slot split, bitmap read
    logic upd;     // bitmap update and status
    logic finish;  // load result register
  } bsa_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic out_free;  // result register can take a new result
  } bsa_sts_t;

endpackage

/* src/bsa_ctrl.sv */
// Controller state machine for the bitmap slot allocator.
module bsa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bsa_pkg::bsa_sts_t sts,
  output bsa_pkg::bsa_cmd_t cmd
);
  import bsa_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOK = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // Decode commands and next state
  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.look  = 1'b1;
        state_nxt = S_READ;
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* src/bsa_dpath.sv */
// Datapath for the bitmap slot allocator: bitmap memory, search, result register.
module bsa_dpath #(
  parameter int SLOTS_PER_CHUNK = 64,
  parameter int NUM_CHUNKS      = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bsa_pkg::bsa_cmd_t          cmd,
  output bsa_pkg::bsa_sts_t          sts,
  input  logic [bsa_pkg::SIZE_W-1:0] shift,
  input  logic                       in_func,
  input  logic [bsa_pkg::ADDR_W-1:0] in_free_address,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [bsa_pkg::ADDR_W-1:0] out_address,
  output logic [bsa_pkg::STAT_W-1:0] out_status
);
  import bsa_pkg::*;

  localparam int CW   = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
  localparam int PW   = $clog2(SLOTS_PER_CHUNK);
  localparam int POOL = NUM_CHUNKS * SLOTS_PER_CHUNK;
  localparam int GW   = $clog2(POOL) + 1;
  localparam int KS   = GW + 8;
  localparam int RECIP = (2 ** KS + SLOTS_PER_CHUNK - 1) / SLOTS_PER_CHUNK;
  localparam int XW   = (GW + SIZE_LOG2_MAX > ADDR_W) ? GW + SIZE_LOG2_MAX : ADDR_W;

  localparam logic [GW-1:0]     SLOTS_G = GW'(SLOTS_PER_CHUNK);
  localparam logic [KS-1:0]     RECIP_K = KS'(RECIP);
  localparam logic [ADDR_W-1:0] POOL_A  = ADDR_W'(POOL);

  // Request capture
  logic              func_r;
  logic [ADDR_W-1:0] faddr_r;

  // Look-up stage
  logic [ADDR_W-1:0] gfull;
  logic [GW+KS-1:0]  prod_r;
  logic [GW-1:0]     gi_r;
  logic              range_r;
  logic              any_free_r;
  logic [CW-1:0]     achunk_r;
  logic [CW-1:0]     achunk_nxt;

  // Read stage
  logic [GW-1:0]     quot;
  logic [GW-1:0]     rem;
  logic [GW-1:0]     quot_nxt;
  logic [GW-1:0]     rem_nxt;
  logic [CW-1:0]     rd_addr;
  logic [CW-1:0]     chunk_r;
  logic [PW-1:0]     fpos_r;
  logic [SLOTS_PER_CHUNK-1:0] rdata_r;
  logic              rvld_r;

  // Bitmap storage and summaries
  logic [SLOTS_PER_CHUNK-1:0] mem [NUM_CHUNKS];
  logic [NUM_CHUNKS-1:0]      row_vld_r;
  logic [NUM_CHUNKS-1:0]      has_free_r;

  // Update stage
  logic [SLOTS_PER_CHUNK-1:0] row;
  logic [SLOTS_PER_CHUNK-1:0] row_nxt;
  logic              mem_we;
  logic [PW-1:0]     apos;
  logic [STAT_W-1:0] stat_nxt;
  logic [PW-1:0]     pos_r;
  logic [STAT_W-1:0] stat_r;
  logic              alloc_ok_r;

  // Result stage
  logic [GW-1:0]     gslot;
  logic [XW-1:0]     gshift;
  logic              out_valid_r;
  logic [ADDR_W-1:0] out_address_r;
  logic [STAT_W-1:0] out_status_r;

  // Lowest chunk with a free slot
  always_comb begin
    achunk_nxt = '0;
    for (int i = NUM_CHUNKS - 1; i >= 0; i--) begin
      if (has_free_r[i]) begin
        achunk_nxt = CW'(i);
      end
    end
  end

  assign gfull = faddr_r >> shift;

  // Split slot index into chunk and slot by reciprocal multiply
  assign quot = prod_r[GW+KS-1:KS];
  assign rem  = gi_r - GW'(quot * SLOTS_G);
  always_comb begin
    quot_nxt = quot;
    rem_nxt  = rem;
    if (rem >= SLOTS_G) begin
      quot_nxt = quot + GW'(1);
      rem_nxt  = rem - SLOTS_G;
    end
  end
  assign rd_addr = (func_r == FUNC_FREE) ? quot_nxt[CW-1:0] : achunk_r;

  // Capture, look up and split
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= in_func;
      faddr_r <= in_free_address;
    end
    if (cmd.look) begin
      range_r    <= (gfull >= POOL_A);
      gi_r       <= gfull[GW-1:0];
      prod_r     <= (GW+KS)'(gfull[GW-1:0]) * (GW+KS)'(RECIP_K);
      any_free_r <= |has_free_r;
      achunk_r   <= achunk_nxt;
    end
    if (cmd.rd) begin
      chunk_r <= rd_addr;
      fpos_r  <= rem_nxt[PW-1:0];
    end
  end

  // Bitmap memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[chunk_r] <= row_nxt;
    end
    if (cmd.rd) begin
      rdata_r <= mem[rd_addr];
      rvld_r  <= row_vld_r[rd_addr];
    end
  end

  // Unwritten rows read as all free
  assign row = rvld_r ? rdata_r : '1;

  // Lowest free slot in the chunk
  always_comb begin
    apos = '0;
    for (int i = SLOTS_PER_CHUNK - 1; i >= 0; i--) begin
      if (row[i]) begin
        apos = PW'(i);
      end
    end
  end

  // Decide update and status
  always_comb begin
    row_nxt  = row;
    mem_we   = 1'b0;
    stat_nxt = ST_OK;
    if (func_r == FUNC_ALLOC) begin
      if (!any_free_r) begin
        stat_nxt = ST_FULL;
      end else begin
        row_nxt[apos] = 1'b0;
        mem_we        = cmd.upd;
      end
    end else if (range_r) begin
      stat_nxt = ST_RANGE;
    end else if (row[fpos_r]) begin
      stat_nxt = ST_DOUBLE;
    end else begin
      row_nxt[fpos_r] = 1'b1;
      mem_we          = cmd.upd;
    end
  end

  // Hold update results
  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      pos_r      <= apos;
      stat_r     <= stat_nxt;
      alloc_ok_r <= (func_r == FUNC_ALLOC) && any_free_r;
    end
  end

  // Track written rows and chunks with free slots
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r  <= '0;
      has_free_r <= '1;
    end else if (mem_we) begin
      row_vld_r[chunk_r]  <= 1'b1;
      has_free_r[chunk_r] <= |row_nxt;
    end
  end

  // Byte offset of the allocated slot
  assign gslot  = GW'(chunk_r * SLOTS_G) + GW'(pos_r);
  assign gshift = XW'(gslot) << shift;

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_address_r <= alloc_ok_r ? gshift[ADDR_W-1:0] : '0;
      out_status_r  <= stat_r;
    end
  end

  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_address  = out_address_r;
  assign out_status   = out_status_r;

endmodule

/* src/bitmap_slot_allocator_top.sv */
// Top level of the bitmap slot allocator: config register, controller, datapath.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------
//  request  | in_valid/in_ready  | in_func, in_free_address
//  result   | out_valid/out_ready| out_address, out_status
//  config   | psel/penable/pready| pwrite, paddr, pwdata, prdata
//
// A request is taken only in idle; after acceptance it passes through the
// slot index and chunk search, the chunk/slot split with bitmap read, the
// bitmap update and the result load. A new request is taken only once the
// controller has passed through all of these steps and is back in idle.
// Reset is synchronous and active low; rows not yet written read as all free,
// so no clearing pass runs. One result is buffered: the next request is taken
// while it waits, and holds in the last stage until the result is taken.
module bitmap_slot_allocator_top #(
  parameter int SLOTS_PER_CHUNK = 64,
  parameter int NUM_CHUNKS      = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_func,
  input  logic [bsa_pkg::ADDR_W-1:0]  in_free_address,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bsa_pkg::ADDR_W-1:0]  out_address,
  output logic [bsa_pkg::STAT_W-1:0]  out_status,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bsa_pkg::PADDR_W-1:0] paddr,
  input  logic [bsa_pkg::PDATA_W-1:0] pwdata,
  output logic [bsa_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import bsa_pkg::*;

  `include "bitmap_slot_allocator_top_assert.svh"

  localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(SIZE_LOG2_MAX);

  logic [SIZE_W-1:0] size_r;
  logic [SIZE_W-1:0] shift;
  logic              cfg_we;
  bsa_cmd_t          cmd_w;
  bsa_sts_t          sts_w;

  // Config register write
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_SIZE_LOG2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= '0;
    end else if (cfg_we) begin
      size_r <= pwdata[SIZE_W-1:0];
    end
  end

  // Config register read
  assign prdata = (paddr[2] == REG_SIZE_LOG2) ? PDATA_W'(size_r) : '0;

  // Clamp the object size
  assign shift = (size_r > SIZE_MAX) ? SIZE_MAX : size_r;

  bsa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts_w),
    .cmd      (cmd_w)
  );

  bsa_dpath #(
    .SLOTS_PER_CHUNK (SLOTS_PER_CHUNK),
    .NUM_CHUNKS      (NUM_CHUNKS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd_w),
    .sts             (sts_w),
    .shift           (shift),
    .in_func         (in_func),
    .in_free_address (in_free_address),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_address     (out_address),
    .out_status      (out_status)
  );

  `BSA_CHECK_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "request taken while busy")
  `BSA_CHECK_NOW(a_result_load, $rose(out_valid), $past(cmd_w.finish), "result without finish")
  `BSA_CHECK_NOW(a_fail_addr, out_valid && (out_status != ST_OK), out_address == '0, "failed request carries an address")
  `BSA_CHECK_NOW(a_cmd_onehot, 1'b1, $onehot0(cmd_w), "overlapping datapath commands")

endmodule

/* tb/tb_bitmap_slot_allocator_top.sv */
// Self-checking testbench for the bitmap slot allocator, built around a slot map predictor.
module tb_bitmap_slot_allocator_top;
  import bsa_pkg::*;

  localparam int SLOTS_PER_CHUNK = 64;
  localparam int NUM_CHUNKS      = 8;
  localparam int POOL_SLOTS      = SLOTS_PER_CHUNK * NUM_CHUNKS;
  localparam int DRAIN_CYCLES    = 10;
  localparam int LONG_HOLD       = 300;
  localparam int LIMIT_CYCLES    = 400000;
  localparam int MAX_REPORTS     = 40;
  localparam int PHASE_ITEMS     = 100;
  localparam logic [PADDR_W-1:0] SIZE_LOG2_ADDR = PADDR_W'(4 * REG_SIZE_LOG2);

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [STAT_W-1:0] status;
  } slot_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                in_func = FUNC_ALLOC;
  logic [ADDR_W-1:0]   in_free_address = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [ADDR_W-1:0]   out_address;
  logic [STAT_W-1:0]   out_status;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  // Slot map predictor state and its copy of the size register
  logic [SLOTS_PER_CHUNK-1:0] free_map [NUM_CHUNKS] = '{default: '1};
  logic [SIZE_W-1:0]          size_log2_reg = '0;

  slot_result_t expected_results [$];
  int error_count     = 0;
  int results_checked = 0;
  int requests_sent   = 0;
  int size_writes     = 0;
  int cycle_count     = 0;
  int burst_left      = 0;
  int status_seen [4] = '{default: 0};
  bit hold_request    = 1'b0;

  bitmap_slot_allocator_top #(
    .SLOTS_PER_CHUNK(SLOTS_PER_CHUNK),
    .NUM_CHUNKS     (NUM_CHUNKS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_free_address(in_free_address),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_address    (out_address),
    .out_status     (out_status),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #10 clk = ~clk;

  // Clamp the object size shift to the largest supported size
  function automatic int object_shift();
    return (size_log2_reg > SIZE_LOG2_MAX) ? SIZE_LOG2_MAX : int'(size_log2_reg);
  endfunction

  function automatic logic slot_is_free(int g);
    return free_map[g / SLOTS_PER_CHUNK][g % SLOTS_PER_CHUNK];
  endfunction

  // Apply one request to the slot map and return the result it produces
  function automatic slot_result_t predict_slot_request(logic func, logic [ADDR_W-1:0] offset);
    slot_result_t r;
    int g;
    r.address = '0;
    r.status  = ST_OK;
    if (func == FUNC_ALLOC) begin
      // Lowest chunk first, lowest slot within it: a flat scan over global slots
      r.status = ST_FULL;
      for (g = 0; g < POOL_SLOTS && r.status == ST_FULL; g++) begin
        if (slot_is_free(g)) begin
          free_map[g / SLOTS_PER_CHUNK][g % SLOTS_PER_CHUNK] = 1'b0;
          r.address = ADDR_W'(g << object_shift());
          r.status  = ST_OK;
        end
      end
    end else begin
      // Low offset bits drop out, so any byte inside a slot names that slot
      g = int'(offset >> object_shift());
      if (g >= POOL_SLOTS)
        r.status = ST_RANGE;
      else if (slot_is_free(g))
        r.status = ST_DOUBLE;
      else
        free_map[g / SLOTS_PER_CHUNK][g % SLOTS_PER_CHUNK] = 1'b1;
    end
    return r;
  endfunction

  function automatic logic pool_has_free();
    logic any_free;
    any_free = 1'b0;
    for (int c = 0; c < NUM_CHUNKS; c++)
      any_free |= |free_map[c];
    return any_free;
  endfunction

  // Find a slot in the wanted state, starting at a random point; -1 if none
  function automatic int pick_slot(logic want_free);
    int start;
    int g;
    start = $urandom_range(0, POOL_SLOTS - 1);
    for (int i = 0; i < POOL_SLOTS; i++) begin
      g = (start + i) % POOL_SLOTS;
      if (slot_is_free(g) == want_free)
        return g;
    end
    return -1;
  endfunction

  // Byte offset of a slot, with random bits inside the object
  function automatic logic [ADDR_W-1:0] slot_offset(int g);
    int sh;
    sh = object_shift();
    return ADDR_W'((g << sh) | ($urandom & ((1 << sh) - 1)));
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Offer one request in bursts with random gaps; predict it once accepted
  task automatic send_request(input logic func, input logic [ADDR_W-1:0] offset);
    slot_result_t want;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid        <= 1'b1;
    in_func         <= func;
    in_free_address <= offset;
    do @(posedge clk); while (!in_ready);
    want = predict_slot_request(func, offset);
    expected_results.push_back(want);
    requests_sent++;
    status_seen[want.status]++;
  endtask

  // Drop valid, wait for every result, then let the pipeline settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write the size register, then read it back
  task automatic write_size_log2(input logic [SIZE_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SIZE_LOG2_ADDR;
    pwdata  <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    size_log2_reg = value;
    size_writes++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[SIZE_W-1:0] !== value)
      report_mismatch("size_log2 readback", int'(prdata[SIZE_W-1:0]), int'(value));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Random request: mostly allocations and frees of live slots, some noise
  task automatic send_random_request(input int alloc_pct);
    int g;
    int roll;
    if ($urandom_range(0, 99) < alloc_pct) begin
      send_request(FUNC_ALLOC, ADDR_W'($urandom));
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 85)
        g = pick_slot(1'b0);
      else if (roll < 93)
        g = pick_slot(1'b1);
      else
        g = -1;
      send_request(FUNC_FREE, (g < 0) ? ADDR_W'($urandom) : slot_offset(g));
    end
  endtask

  // Size from reset: basic allocate/free, double free, range edges
  task automatic test_reset_state();
    send_request(FUNC_ALLOC, '0);
    send_request(FUNC_ALLOC, '0);
    send_request(FUNC_FREE, ADDR_W'(0));
    send_request(FUNC_FREE, ADDR_W'(0));
    send_request(FUNC_ALLOC, '0);
    send_request(FUNC_FREE, '1);
    send_request(FUNC_FREE, ADDR_W'(POOL_SLOTS));
    send_request(FUNC_FREE, ADDR_W'(POOL_SLOTS - 1));
    send_request(FUNC_ALLOC, '1);
    send_request(FUNC_FREE, ADDR_W'(1));
    wait_idle();
  endtask

  // Size values above the maximum behave as the maximum
  task automatic test_oversized_size();
    write_size_log2(4'd15);
    send_request(FUNC_ALLOC, '0);
    send_request(FUNC_FREE, ADDR_W'((1 << SIZE_LOG2_MAX) + (1 << SIZE_LOG2_MAX) - 1));
    send_request(FUNC_FREE, '1);
    send_request(FUNC_ALLOC, '0);
    wait_idle();
  endtask

  // Offsets inside a slot free that slot; one slot past the pool is out of range
  task automatic test_misaligned_free();
    write_size_log2(4'd3);
    send_request(FUNC_FREE, ADDR_W'((1 << 3) + 5));
    send_request(FUNC_FREE, ADDR_W'(((POOL_SLOTS - 1) << 3) + 7));
    send_request(FUNC_FREE, ADDR_W'(POOL_SLOTS << 3));
    send_request(FUNC_ALLOC, '0);
    wait_idle();
  endtask

  // Fill the pool while results are held off, then churn near the full mark
  task automatic test_pool_full_under_stall();
    int g;
    write_size_log2(SIZE_W'(SIZE_LOG2_MAX));
    hold_request = 1'b1;
    while (pool_has_free())
      send_request(FUNC_ALLOC, ADDR_W'($urandom));
    send_request(FUNC_ALLOC, '0);
    send_request(FUNC_ALLOC, '1);
    repeat (40) begin
      g = pick_slot(1'b0);
      send_request(FUNC_FREE, slot_offset(g));
    end
    repeat (10) send_request(FUNC_ALLOC, ADDR_W'($urandom));
    repeat (3) begin
      g = pick_slot(1'b1);
      send_request(FUNC_FREE, slot_offset(g));
    end
    wait_idle();
  endtask

  // Random traffic in phases with different sizes and allocate ratios
  task automatic test_random_traffic();
    logic [SIZE_W-1:0] phase_size [6];
    int                phase_alloc [6];
    phase_size  = '{4'd0, 4'd12, 4'd15, 4'd13, SIZE_W'($urandom_range(1, 11)),
                    SIZE_W'($urandom)};
    phase_alloc = '{50, 20, 80, 45, $urandom_range(35, 65), $urandom_range(35, 65)};
    for (int p = 0; p < 6; p++) begin
      write_size_log2(phase_size[p]);
      repeat (PHASE_ITEMS) send_random_request(phase_alloc[p]);
      wait_idle();
    end
  endtask

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin : check_results
    slot_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with no request pending, address", int'(out_address), -1);
      end else begin
        want = expected_results.pop_front();
        if (out_address !== want.address)
          report_mismatch($sformatf("address of result %0d", results_checked),
                          int'(out_address), int'(want.address));
        if (out_status !== want.status)
          report_mismatch($sformatf("status of result %0d", results_checked),
                          int'(out_status), int'(want.status));
      end
      results_checked++;
    end
  end

  // Stall the result side on changing patterns, with one long hold on request
  int hold_left    = 0;
  int pattern_left = 0;
  int ready_mode   = 0;
  int ready_tick   = 0;
  always @(posedge clk) begin
    if (hold_request) begin
      hold_left    = LONG_HOLD;
      hold_request = 1'b0;
    end
    if (pattern_left == 0) begin
      ready_mode   = $urandom_range(0, 3);
      pattern_left = $urandom_range(32, 160);
    end
    pattern_left--;
    ready_tick++;
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (ready_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ((ready_tick % 8) >= 3);
      endcase
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("[%0t] timeout after %0d cycles, %0d results outstanding",
               $time, cycle_count, expected_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_oversized_size();
    test_misaligned_free();
    test_pool_full_under_stall();
    test_random_traffic();
    $display("Covered %0d requests and %0d results over %0d size writes, incl. a full pool",
             requests_sent, results_checked, size_writes);
    $display("Outcomes: %0d ok, %0d pool full, %0d double free, %0d out of range",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_DOUBLE],
             status_seen[ST_RANGE]);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
